// ----- sv/auth_failure_line_matcher_defines.svh -----
// ----------------------------------------------------------------------------
// Auth failure line matcher assertion macros
// Shared concurrent assertion forms clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef AUTH_FAILURE_LINE_MATCHER_DEFINES_SVH
`define AUTH_FAILURE_LINE_MATCHER_DEFINES_SVH

// same-cycle implication
`define AFLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/aflm_pkg.sv -----
// ----------------------------------------------------------------------------
// Auth failure line matcher package
// Window size, signature constants and the types passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aflm_pkg;

    localparam int WINDOW_BYTES = 22;
    localparam int HIST_W       = 8 * (WINDOW_BYTES - 1);
    localparam int WIN_W        = 8 * WINDOW_BYTES;
    localparam int CNT_W        = 4;

    localparam logic [7:0]       NEWLINE_BYTE    = 8'd10;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd5;

    // string literals pack the first character in the top byte
    localparam logic [8*15-1:0] SIG_FAILED_PASSWORD = "Failed password";
    localparam logic [8*22-1:0] SIG_AUTH_FAILURE    = "authentication failure";
    localparam logic [8*12-1:0] SIG_INVALID_USER    = "Invalid user";
    localparam logic [8*8-1:0]  SIG_BREAK_IN        = "BREAK-IN";
    localparam logic [8*21-1:0] SIG_AUTH_FAILED     = "authentication failed";

    typedef struct packed {
        logic       last;
        logic [7:0] text_byte;
    } t_stage;

    // line_suspicious in the lowest bit
    typedef struct packed {
        logic [CNT_W-1:0] failure_count;
        logic             alert_raised;
        logic             line_suspicious;
    } t_result;

    function automatic logic is_line_end(input t_stage s);
        return (s.text_byte == NEWLINE_BYTE) || s.last;
    endfunction

endpackage

`default_nettype wire

// ----- sv/aflm_window.sv -----
// ----------------------------------------------------------------------------
// Auth failure line matcher byte window
// Holds the previous bytes of the line and compares the window ending at the
// current byte with all signatures in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module aflm_window (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire aflm_pkg::t_stage i_stage,
    output logic                 o_hit
);
    import aflm_pkg::*;

    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic [WIN_W-1:0]  win;

    // most recent byte in the lowest bits
    assign win = {r_hist, i_stage.text_byte};

    always_comb begin
        o_hit = (win[$bits(SIG_FAILED_PASSWORD)-1:0] == SIG_FAILED_PASSWORD)
             || (win[$bits(SIG_AUTH_FAILURE)-1:0]    == SIG_AUTH_FAILURE)
             || (win[$bits(SIG_INVALID_USER)-1:0]    == SIG_INVALID_USER)
             || (win[$bits(SIG_BREAK_IN)-1:0]        == SIG_BREAK_IN)
             || (win[$bits(SIG_AUTH_FAILED)-1:0]     == SIG_AUTH_FAILED);
    end

    always_comb begin
        n_hist = r_hist;
        if (i_advance) begin
            if (is_line_end(i_stage)) begin
                n_hist = '0;
            end else begin
                n_hist = win[HIST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= n_hist;
        end
    end

endmodule

`default_nettype wire

// ----- sv/aflm_line_stat.sv -----
// ----------------------------------------------------------------------------
// Auth failure line matcher line statistics
// Tracks the per-line match flag and the suspicious line count, and forms the
// result for each closed line.
// ----------------------------------------------------------------------------
`default_nettype none

module aflm_line_stat (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_advance,
    input  wire aflm_pkg::t_stage         i_stage,
    input  wire logic                     i_hit,
    input  wire logic [aflm_pkg::CNT_W-1:0] i_threshold,
    output logic                          o_close,
    output aflm_pkg::t_result             o_result
);
    import aflm_pkg::*;

    logic             r_line_matched;
    logic             n_line_matched;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             matched;
    logic [CNT_W-1:0] count_inc;
    logic             alert;

    assign o_close   = is_line_end(i_stage);
    assign matched   = r_line_matched || i_hit;
    assign count_inc = r_count + CNT_W'(1);
    assign alert     = matched && (count_inc >= i_threshold);

    always_comb begin
        o_result.line_suspicious = matched;
        o_result.alert_raised    = alert;
        if (!matched) begin
            o_result.failure_count = r_count;
        end else if (alert) begin
            o_result.failure_count = '0;
        end else begin
            o_result.failure_count = count_inc;
        end
    end

    always_comb begin
        n_line_matched = r_line_matched;
        n_count        = r_count;
        if (i_advance) begin
            if (o_close) begin
                n_line_matched = 1'b0;
                n_count        = o_result.failure_count;
            end else begin
                n_line_matched = matched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_matched <= 1'b0;
            r_count        <= '0;
        end else begin
            r_line_matched <= n_line_matched;
            r_count        <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- sv/auth_failure_line_matcher.sv -----
// ----------------------------------------------------------------------------
// Auth failure line matcher
// Scans a byte stream for authentication-failure phrases, reports one result
// per line and raises an alert when the suspicious line count hits threshold.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+----------------------------------
//  s_axis   | in  | tvalid/tready           | tdata[7:0] text_byte, tlast eoi
//  m_axis   | out | tvalid/tready           | tdata: suspicious, alert, count
//  cfg      | in  | i_cfg_wr_en             | i_cfg_wr_data alert_threshold
//
//  One byte per cycle while the result is not stalled; a closing byte's result
//  passes through the input register, then the result register.
//  Synchronous active-low reset clears window, counters and valids; the
//  threshold returns to 5.
//  A stalled result holds both stages; input stays open while the result
//  register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module auth_failure_line_matcher (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,  // [7:0] text_byte
    input  wire logic                       s_axis_tlast,  // end_of_input
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [0] line_suspicious, [1] alert_raised, [5:2] failure_count, [7:6] zero
    output logic [7:0]                      m_axis_tdata,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [aflm_pkg::CNT_W-1:0] i_cfg_wr_data
);
    import aflm_pkg::*;

    logic             r_in_valid;
    t_stage           r_in;
    logic             r_out_valid;
    t_result          r_out;
    logic [CNT_W-1:0] r_threshold;

    logic    out_free;
    logic    advance;
    logic    hit;
    logic    close;
    t_result result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    aflm_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_stage   (r_in),
        .o_hit     (hit)
    );

    aflm_line_stat u_line_stat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_stage     (r_in),
        .i_hit       (hit),
        .i_threshold (r_threshold),
        .o_close     (close),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.text_byte <= s_axis_tdata;
            r_in.last      <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && close) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

// ----- sv/aflm_checker.sv -----
// ----------------------------------------------------------------------------
// Auth failure line matcher checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "auth_failure_line_matcher_defines.svh"

module aflm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    logic       out_stall;
    logic       out_alert;
    logic [8:0] out_bus;
    logic [3:0] out_count;
    logic [1:0] out_pad;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_alert = m_axis_tvalid && m_axis_tdata[1];
    assign out_bus   = {m_axis_tvalid, m_axis_tdata};
    assign out_count = m_axis_tdata[5:2];
    assign out_pad   = m_axis_tdata[7:6];

    `AFLM_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_bus), "result changed while stalled")

    `AFLM_ASSERT_NOW(a_alert_needs_match, out_alert, m_axis_tdata[0], "alert on a clean line")

    `AFLM_ASSERT_NOW(a_alert_clears, out_alert, out_count == '0, "count not cleared on alert")

    `AFLM_ASSERT_NOW(a_pad_zero, m_axis_tvalid, out_pad == 2'b00, "result padding not zero")

endmodule

bind auth_failure_line_matcher aflm_checker u_aflm_checker (.*);

`default_nettype wire

// ----- test/tb_auth_failure_line_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Auth failure line matcher testbench
// Streams log text through the matcher with random stalls on both sides and
// predicts one verdict per closed line: signature hit, alert and running
// failure count. Runs a short directed prologue, then random lines built
// from clean filler, intact and damaged phrases, under several thresholds.
// ----------------------------------------------------------------------------
module tb_auth_failure_line_matcher;
    import aflm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;

    class failure_line_scoreboard;
        string            phrases[5];
        logic [7:0]       history[WINDOW_BYTES-1];
        bit               line_hit;
        logic [CNT_W-1:0] fail_count;
        logic [CNT_W-1:0] alert_level;
        t_result          verdicts_due[$];
        int               errors;

        function new();
            phrases = '{"Failed password", "authentication failure", "Invalid user",
                        "BREAK-IN", "authentication failed"};
            foreach (history[i]) history[i] = '0;
            line_hit    = 1'b0;
            fail_count  = '0;
            alert_level = THRESHOLD_RESET;
            errors      = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [7:0] win[WINDOW_BYTES];
            t_result    v;
            int         base;
            bit         hit;
            for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] = history[i];
            win[WINDOW_BYTES-1] = b;
            foreach (phrases[k]) begin
                base = WINDOW_BYTES - phrases[k].len();
                hit  = 1'b1;
                for (int i = 0; i < phrases[k].len(); i++) begin
                    if (win[base+i] != phrases[k][i]) hit = 1'b0;
                end
                if (hit) line_hit = 1'b1;
            end
            for (int i = 0; i < WINDOW_BYTES - 1; i++) history[i] = win[i+1];
            if (b != NEWLINE_BYTE && !last) return;

            v.line_suspicious = line_hit;
            v.alert_raised    = 1'b0;
            if (line_hit) begin
                fail_count = fail_count + CNT_W'(1);
                if (fail_count >= alert_level) begin
                    v.alert_raised = 1'b1;
                    fail_count     = '0;
                end
            end
            v.failure_count = fail_count;
            verdicts_due.push_back(v);
            foreach (history[i]) history[i] = '0;
            line_hit = 1'b0;
        endfunction

        function void check_verdict(logic [7:0] data);
            t_result got, want;
            got = t_result'(data[5:0]);
            if (verdicts_due.size() == 0) begin
                $error("unexpected result transaction, tdata %h", data);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.line_suspicious !== want.line_suspicious) begin
                $error("line_suspicious: expected %0d, actual %0d",
                       want.line_suspicious, got.line_suspicious);
                errors++;
            end
            if (got.alert_raised !== want.alert_raised) begin
                $error("alert_raised: expected %0d, actual %0d",
                       want.alert_raised, got.alert_raised);
                errors++;
            end
            if (got.failure_count !== want.failure_count) begin
                $error("failure_count: expected %0d, actual %0d",
                       want.failure_count, got.failure_count);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             s_axis_tvalid  = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata   = '0;
    logic             s_axis_tlast   = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready  = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic             i_cfg_wr_en    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wr_data  = '0;

    failure_line_scoreboard sb = new();
    bit no_idle     = 1'b0;
    int sent_items  = 0;
    int idle_cycles = 0;

    auth_failure_line_matcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, last);
        sent_items++;
    endtask

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 80) return 8'($urandom_range(32, 126));
        do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_BYTE);
        return b;
    endfunction

    function automatic int filler_len();
        if ($urandom_range(19) == 0) return $urandom_range(30, 90);
        return $urandom_range(0, 6);
    endfunction

    // filler, optional phrase (sometimes damaged), filler, then a line end
    task automatic send_line();
        logic [7:0] text[$];
        string      phrase;
        int         pick, pos, end_kind;
        bit         mark;
        repeat (filler_len()) text.push_back(filler_byte());
        pick = $urandom_range(99);
        if (pick < 60) begin
            phrase = sb.phrases[$urandom_range(4)];
            for (int i = 0; i < phrase.len(); i++) text.push_back(phrase[i]);
            if (pick >= 45) begin
                pos = text.size() - 1 - $urandom_range(phrase.len() - 1);
                case ($urandom_range(2))
                    0: text[pos] = text[pos] ^ (8'd1 << $urandom_range(7));
                    1: text.delete(pos);
                    default: text.insert(pos, NEWLINE_BYTE);
                endcase
            end
        end
        repeat (filler_len()) text.push_back(filler_byte());
        end_kind = $urandom_range(9);
        mark     = (end_kind >= 6);
        if (end_kind < 8 || text.size() == 0) text.push_back(NEWLINE_BYTE);
        foreach (text[i]) send_byte(text[i], mark && (i == text.size() - 1));
    endtask

    task automatic run_lines(input int n);
        int target;
        target = sent_items + n;
        while (sent_items < target) send_line();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CNT_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.alert_level = v;
    endtask

    initial begin
        string head;
        head = "BREAK-IN\n";
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shortest phrase, zero and all-ones bytes, end marks on newline and text
        for (int i = 0; i < head.len(); i++) send_byte(head[i], 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b1);
        send_byte("Z", 1'b1);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_byte(8'h00, 1'b1);
        run_lines(300);

        drain();
        write_threshold(4'd15);
        run_lines(700);

        // lowered threshold, no stalls on either side
        drain();
        write_threshold(4'd1);
        no_idle = 1'b1;
        run_lines(250);
        no_idle = 1'b0;

        drain();
        write_threshold(4'd0);
        run_lines(250);

        drain();
        write_threshold(4'($urandom_range(2, 14)));
        run_lines(300);

        drain();
        write_threshold(4'd3);
        run_lines(200);

        drain();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
